FILE: hw/rtl/art_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// art_pkg
// Shared types and constants for the allocation range tracker.
// ----------------------------------------------------------------------------
package art_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int MAX_DIMS      = 4;
    localparam int DIM_FIELDS    = 4;
    localparam int DIM_LIMIT     = (MAX_DIMS < DIM_FIELDS) ? MAX_DIMS : DIM_FIELDS;
    localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int DIM_IW        = (DIM_LIMIT > 1) ? $clog2(DIM_LIMIT) : 1;
    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_PW       = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW       = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] MODE_INSERT  = 2'd0;
    localparam logic [1:0] MODE_REMOVE  = 2'd1;
    localparam logic [1:0] MODE_CONTAIN = 2'd2;
    localparam logic [1:0] MODE_EXACT   = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOTFOUND = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_ZERO     = 3'd3;
    localparam logic [2:0] ST_OVF      = 3'd4;

    typedef logic [DIM_LIMIT-1:0][15:0] ext_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] address;
        logic [31:0] elem_bytes;
        logic [2:0]  num_dims;
        logic [15:0] dim_0;
        logic [15:0] dim_1;
        logic [15:0] dim_2;
        logic [15:0] dim_3;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] entry_start;
        logic [31:0] entry_elem_bytes;
        logic [63:0] entry_elems;
        logic [63:0] entry_bytes;
        logic [2:0]  entry_dims;
        logic [63:0] flat_index;
        logic [63:0] index_0;
        logic [63:0] index_1;
        logic [63:0] index_2;
        logic [63:0] index_3;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] address;
        logic [31:0] elem_bytes;
        logic [2:0]  nd;
        ext_t        ext;
    } cmd_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
        logic [31:0] rem;
    } div_rsp_t;

endpackage

FILE: hw/rtl/art_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// art_div
// Restoring 64 by 32 bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module art_div
    import art_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [63:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] r_shift;

    always_comb
    begin
        r_shift = {r_reg[31:0], q_reg[63]};
        if (r_shift >= {1'b0, d_reg})
        begin
            r_next = r_shift - {1'b0, d_reg};
            q_next = {q_reg[62:0], 1'b1};
        end
        else
        begin
            r_next = r_shift;
            q_next = {q_reg[62:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            q_reg    <= '0;
            r_reg    <= '0;
            d_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                q_reg    <= req.dividend;
                r_reg    <= '0;
                d_reg    <= req.divisor;
            end
            else if (busy_reg)
            begin
                q_reg   <= q_next;
                r_reg   <= r_next;
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
    assign rsp.rem  = r_reg[31:0];

endmodule

FILE: hw/rtl/art_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// art_front
// Accepts items, clamps the dimension count and queues commands.
// ----------------------------------------------------------------------------
module art_front
    import art_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t in_item,
    output logic     full,
    output logic     cmd_valid,
    output cmd_t     cmd,
    input  logic     cmd_pop
);

    cmd_t                q_mem [FIFO_DEPTH];
    logic [FIFO_PW-1:0]  wr_ptr_reg;
    logic [FIFO_PW-1:0]  rd_ptr_reg;
    logic [FIFO_CW-1:0]  cnt_reg;
    cmd_t                new_cmd;
    logic [DIM_FIELDS-1:0][15:0] dims;
    logic                do_push;
    logic                do_pop;

    always_comb
    begin
        dims = {in_item.dim_3, in_item.dim_2, in_item.dim_1, in_item.dim_0};
        new_cmd.mode       = in_item.mode;
        new_cmd.address    = in_item.address;
        new_cmd.elem_bytes = in_item.elem_bytes;
        if (in_item.num_dims > 3'(DIM_LIMIT))
            new_cmd.nd = 3'(DIM_LIMIT);
        else
            new_cmd.nd = in_item.num_dims;
        for (int i = 0; i < DIM_LIMIT; i++)
            new_cmd.ext[i] = dims[i];
    end

    assign full      = (cnt_reg == FIFO_CW'(FIFO_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wr_ptr_reg] <= new_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PW'(FIFO_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PW'(FIFO_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

FILE: hw/rtl/art_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// art_back
// Executes queued commands against the allocation table and holds the result.
// ----------------------------------------------------------------------------
module art_back
    import art_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_pop,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_PROD, S_MLO, S_MHI, S_SUM, S_END,
        S_SCAN, S_EXEC, S_DIVW, S_RADIX, S_RWAIT
    } state_t;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_ENTRIES - 1);

    // table storage
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] ranged_reg;
    logic [63:0] start_mem [TABLE_ENTRIES];
    logic [63:0] end_mem   [TABLE_ENTRIES];
    logic [31:0] es_mem    [TABLE_ENTRIES];
    logic [2:0]  nd_mem    [TABLE_ENTRIES];
    logic [63:0] elems_mem [TABLE_ENTRIES];
    logic [63:0] bytes_mem [TABLE_ENTRIES];
    ext_t        ext_mem   [TABLE_ENTRIES];

    state_t      state_reg;
    cmd_t        cmd_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [2:0]  d_reg;
    logic [63:0] elems_reg;
    logic [63:0] plo_reg;
    logic [63:0] phi_reg;
    logic [63:0] bytes_reg;
    logic [63:0] end_reg;
    logic        ovf_reg;
    logic        hit_reg;
    logic [SLOT_W-1:0] hit_idx_reg;
    logic        free_reg;
    logic [SLOT_W-1:0] free_idx_reg;
    logic [63:0] cap_start_reg;
    logic [31:0] cap_es_reg;
    logic [63:0] cap_elems_reg;
    logic [63:0] cap_bytes_reg;
    logic [2:0]  cap_nd_reg;
    ext_t        cap_ext_reg;
    logic [63:0] off_reg;
    out_item_t   res_reg;
    logic        res_valid_reg;
    logic        track_reg;

    div_req_t    div_req;
    div_rsp_t    div_rsp;

    logic        tbl_we;
    logic [SLOT_W-1:0] tbl_widx;
    logic [64:0] sum65;
    logic [64:0] end65;
    logic        scan_v;
    logic [63:0] scan_start;
    logic        match_start;
    logic        match_contain;
    logic [15:0] cur_ext;
    logic        more_dims;

    art_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cfg_ready = 1'b1;
    assign empty     = !res_valid_reg;
    assign out_item  = res_reg;
    assign cmd_pop   = (state_reg == S_IDLE) && cmd_valid && !res_valid_reg;

    always_comb
    begin
        sum65       = {1'b0, plo_reg} + {1'b0, phi_reg[31:0], 32'b0};
        end65       = {1'b0, cmd_reg.address} + {1'b0, bytes_reg};
        scan_v      = valid_reg[idx_reg];
        scan_start  = start_mem[idx_reg];
        match_start = scan_v && (scan_start == cmd_reg.address);
        match_contain = scan_v && ranged_reg[idx_reg]
                        && (scan_start <= cmd_reg.address)
                        && (cmd_reg.address < end_mem[idx_reg])
                        && (!hit_reg || (scan_start > cap_start_reg));
        cur_ext     = cap_ext_reg[d_reg[DIM_IW-1:0]];
        more_dims   = ({1'b0, d_reg} + 4'd1) < {1'b0, cap_nd_reg};

        tbl_we   = (state_reg == S_EXEC) && (cmd_reg.mode == MODE_INSERT)
                   && (hit_reg || free_reg);
        tbl_widx = hit_reg ? hit_idx_reg : free_idx_reg;

        div_req.start    = 1'b0;
        div_req.dividend = off_reg;
        div_req.divisor  = {16'b0, cur_ext};
        if ((state_reg == S_EXEC) && (cmd_reg.mode == MODE_CONTAIN) && hit_reg)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = cmd_reg.address - cap_start_reg;
            div_req.divisor  = cap_es_reg;
        end
        else if ((state_reg == S_RADIX) && (cap_nd_reg != 3'd0) && more_dims
                 && (cur_ext != 16'd0))
        begin
            div_req.start = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            start_mem[tbl_widx] <= cmd_reg.address;
            end_mem[tbl_widx]   <= end_reg;
            es_mem[tbl_widx]    <= cmd_reg.elem_bytes;
            nd_mem[tbl_widx]    <= cmd_reg.nd;
            elems_mem[tbl_widx] <= elems_reg;
            bytes_mem[tbl_widx] <= bytes_reg;
            ext_mem[tbl_widx]   <= cmd_reg.ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            ranged_reg    <= '0;
            res_valid_reg <= 1'b0;
            track_reg     <= 1'b1;
            res_reg       <= '0;
            cmd_reg       <= '0;
            idx_reg       <= '0;
            d_reg         <= '0;
            elems_reg     <= '0;
            plo_reg       <= '0;
            phi_reg       <= '0;
            bytes_reg     <= '0;
            end_reg       <= '0;
            ovf_reg       <= 1'b0;
            hit_reg       <= 1'b0;
            hit_idx_reg   <= '0;
            free_reg      <= 1'b0;
            free_idx_reg  <= '0;
            cap_start_reg <= '0;
            cap_es_reg    <= '0;
            cap_elems_reg <= '0;
            cap_bytes_reg <= '0;
            cap_nd_reg    <= '0;
            cap_ext_reg   <= '0;
            off_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
                track_reg <= cfg_data;
            if (pop && res_valid_reg)
                res_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_pop)
                    begin
                        cmd_reg   <= cmd;
                        res_reg   <= '0;
                        hit_reg   <= 1'b0;
                        free_reg  <= 1'b0;
                        idx_reg   <= '0;
                        d_reg     <= '0;
                        elems_reg <= 64'd1;
                        state_reg <= (cmd.mode == MODE_INSERT) ? S_PROD : S_SCAN;
                    end
                end
                S_PROD:
                begin
                    if (d_reg == cmd_reg.nd)
                        state_reg <= S_MLO;
                    else
                    begin
                        elems_reg <= {16'b0, elems_reg[47:0]}
                                     * {48'b0, cmd_reg.ext[d_reg[DIM_IW-1:0]]};
                        d_reg <= d_reg + 3'd1;
                    end
                end
                S_MLO:
                begin
                    plo_reg   <= {32'b0, elems_reg[31:0]} * {32'b0, cmd_reg.elem_bytes};
                    state_reg <= S_MHI;
                end
                S_MHI:
                begin
                    phi_reg   <= {32'b0, elems_reg[63:32]} * {32'b0, cmd_reg.elem_bytes};
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    bytes_reg <= sum65[63:0];
                    ovf_reg   <= sum65[64] || (phi_reg[63:32] != 32'b0);
                    state_reg <= S_END;
                end
                S_END:
                begin
                    end_reg <= end65[63:0];
                    if (cmd_reg.elem_bytes == 32'b0)
                    begin
                        res_reg.status <= ST_ZERO;
                        res_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                    else if (ovf_reg || end65[64])
                    begin
                        res_reg.status <= ST_OVF;
                        res_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                    else
                        state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if ((cmd_reg.mode == MODE_CONTAIN) ? match_contain
                                                       : (match_start && !hit_reg))
                    begin
                        hit_reg       <= 1'b1;
                        hit_idx_reg   <= idx_reg;
                        cap_start_reg <= scan_start;
                        cap_es_reg    <= es_mem[idx_reg];
                        cap_elems_reg <= elems_mem[idx_reg];
                        cap_bytes_reg <= bytes_mem[idx_reg];
                        cap_nd_reg    <= nd_mem[idx_reg];
                        cap_ext_reg   <= ext_mem[idx_reg];
                    end
                    if (!scan_v && !free_reg)
                    begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= idx_reg;
                    end
                    if (idx_reg == LAST_SLOT)
                        state_reg <= S_EXEC;
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_EXEC:
                begin
                    if ((cmd_reg.mode == MODE_CONTAIN) && hit_reg)
                        state_reg <= S_DIVW;
                    else
                    begin
                        state_reg     <= S_IDLE;
                        res_valid_reg <= 1'b1;
                    end
                    if (cmd_reg.mode == MODE_INSERT)
                    begin
                        if (hit_reg || free_reg)
                        begin
                            valid_reg[tbl_widx]      <= 1'b1;
                            ranged_reg[tbl_widx]     <= track_reg;
                            res_reg.status           <= ST_OK;
                            res_reg.entry_start      <= cmd_reg.address;
                            res_reg.entry_elem_bytes <= cmd_reg.elem_bytes;
                            res_reg.entry_elems      <= elems_reg;
                            res_reg.entry_bytes      <= bytes_reg;
                            res_reg.entry_dims       <= cmd_reg.nd;
                        end
                        else
                            res_reg.status <= ST_FULL;
                    end
                    else if (hit_reg)
                    begin
                        res_reg.status           <= ST_OK;
                        res_reg.entry_start      <= cap_start_reg;
                        res_reg.entry_elem_bytes <= cap_es_reg;
                        res_reg.entry_elems      <= cap_elems_reg;
                        res_reg.entry_bytes      <= cap_bytes_reg;
                        res_reg.entry_dims       <= cap_nd_reg;
                        if (cmd_reg.mode == MODE_REMOVE)
                            valid_reg[hit_idx_reg] <= 1'b0;
                    end
                    else
                        res_reg.status <= ST_NOTFOUND;
                end
                S_DIVW:
                begin
                    if (div_rsp.done)
                    begin
                        res_reg.flat_index <= div_rsp.quot;
                        off_reg            <= div_rsp.quot;
                        d_reg              <= '0;
                        state_reg          <= S_RADIX;
                    end
                end
                S_RADIX:
                begin
                    if (cap_nd_reg == 3'd0)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else if (more_dims)
                    begin
                        if (cur_ext == 16'd0)
                            d_reg <= d_reg + 3'd1;
                        else
                            state_reg <= S_RWAIT;
                    end
                    else
                    begin
                        case (d_reg)
                            3'd0:    res_reg.index_0 <= off_reg;
                            3'd1:    res_reg.index_1 <= off_reg;
                            3'd2:    res_reg.index_2 <= off_reg;
                            3'd3:    res_reg.index_3 <= off_reg;
                            default: ;
                        endcase
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_RWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        case (d_reg)
                            3'd0:    res_reg.index_0 <= {32'b0, div_rsp.rem};
                            3'd1:    res_reg.index_1 <= {32'b0, div_rsp.rem};
                            3'd2:    res_reg.index_2 <= {32'b0, div_rsp.rem};
                            3'd3:    res_reg.index_3 <= {32'b0, div_rsp.rem};
                            default: ;
                        endcase
                        off_reg   <= div_rsp.quot;
                        d_reg     <= d_reg + 3'd1;
                        state_reg <= S_RADIX;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // work only starts with the result register free
    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !res_valid_reg)
        else $error("result valid while a command is in progress");

    a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && res_valid_reg) |=> !res_valid_reg)
        else $error("result not retired after pop");

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> ((state_reg == S_DIVW) || (state_reg == S_RWAIT)))
        else $error("divider finished outside a wait state");

endmodule

FILE: hw/rtl/allocation_range_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allocation_range_tracker
// Table of tracked allocations with insert, remove and address lookups.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter through push/full (accepted when push and not full) and
//   results leave through empty/pop, one result per item, in order.
//   cfg_valid/cfg_ready writes the range-tracking enable; cfg_ready is high.
//   A two-entry command queue lets items be taken while the executor works
//   or while a result waits to be popped.
//   The executor scans the table one slot a cycle. An insert first forms
//   the element and byte counts; a containing lookup then uses the shared
//   one-bit-per-cycle divider for the flat index and for each nonzero
//   extent among the first num_dims - 1 dimensions.
//   Reset empties the table, enables range tracking and drops queued items.
//   A result not popped holds the executor; the queue then fills and full
//   rises.
// ----------------------------------------------------------------------------
module allocation_range_tracker
    import art_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  in_item_t  in_item,
    output logic      full,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    art_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_item   (in_item),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    art_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

endmodule
